### design/ballistic_low_arc_aim_core_macros.svh
// ----------------------------------------------------------------------------
// Ballistic low-arc aim core: assertion macros
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BALLISTIC_LOW_ARC_AIM_CORE_MACROS_SVH
`define BALLISTIC_LOW_ARC_AIM_CORE_MACROS_SVH

// Plain property check.
`define BLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Antecedent this cycle, consequent the next cycle.
`define BLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bla_pkg.sv
// ----------------------------------------------------------------------------
// bla_pkg
// Shared types, widths and constants of the ballistic low-arc aim core.
// ----------------------------------------------------------------------------
`default_nettype none

package bla_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int NORM_STAGES  = 6;
    localparam int CORD_LAT     = 1 + NORM_STAGES + CORDIC_STEPS;

    localparam int SQ_IN_W  = 84;   // radicand width
    localparam int SQ_OUT_W = 42;   // root width, one bit per stage
    localparam int VEC_W    = 51;   // signed CORDIC input components
    localparam int MAG_W    = 57;   // normalized magnitude, top bit 56
    localparam int CX_W     = 61;   // CORDIC x/y datapath
    localparam int ANG_W    = 26;   // angle in 1/65536 degree

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);

    localparam logic signed [15:0] PITCH_MAX = 16'sd23040;
    localparam logic signed [16:0] YAW_MAX   = 17'sd46080;

    localparam logic signed [16:0] GRAVITY_RESET = 17'sd980;

    typedef enum logic [1:0] {
        ST_SOLVED   = 2'd0,
        ST_UNREACH  = 2'd1,
        ST_VERTICAL = 2'd2
    } t_aim_status;

    typedef enum logic {
        CFG_LAUNCH_SPEED  = 1'b0,
        CFG_GRAVITY_ACCEL = 1'b1
    } t_cfg_index;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    localparam logic signed [ANG_W-1:0] ATAN_TAB [32] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0,
        26'sd0,       26'sd0,       26'sd0,      26'sd0
    };

endpackage

`default_nettype wire

### design/bla_isqrt.sv
// ----------------------------------------------------------------------------
// bla_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bla_isqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [bla_pkg::SQ_IN_W-1:0]  i_val,
    output logic      [bla_pkg::SQ_OUT_W-1:0] o_root
);

    localparam int N = bla_pkg::SQ_OUT_W;
    localparam int W = bla_pkg::SQ_IN_W;

    logic [W-1:0] r_op  [N];
    logic [W-1:0] r_res [N];
    logic [W-1:0] n_op  [N];
    logic [W-1:0] n_res [N];

    always_comb begin
        logic [W-1:0] op;
        logic [W-1:0] res;
        logic [W-1:0] one;
        logic [W-1:0] trial;
        for (int k = 0; k < N; k++) begin
            op  = (k == 0) ? i_val : r_op[k-1];
            res = (k == 0) ? '0 : r_res[k-1];
            one = W'(1) << (2 * (N - 1 - k));
            trial = res + one;
            if (op >= trial) begin
                n_op[k]  = op - trial;
                n_res[k] = (res >> 1) + one;
            end else begin
                n_op[k]  = op;
                n_res[k] = res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_op[k]  <= n_op[k];
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_root = r_res[N-1][N-1:0];

endmodule

`default_nettype wire

### design/bla_cordic.sv
// ----------------------------------------------------------------------------
// bla_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in 1/65536 degree.
// Quadrant fold, staged normalizing shift, then one rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bla_cordic (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [bla_pkg::VEC_W-1:0] i_y,
    input  wire logic signed [bla_pkg::VEC_W-1:0] i_x,
    output logic signed      [bla_pkg::ANG_W-1:0] o_angle
);

    localparam int VW = bla_pkg::VEC_W;
    localparam int MW = bla_pkg::MAG_W;
    localparam int CW = bla_pkg::CX_W;
    localparam int AW = bla_pkg::ANG_W;
    localparam int NS = bla_pkg::NORM_STAGES;
    localparam int CS = bla_pkg::CORDIC_STEPS;

    // fold stage
    logic              w_xneg;
    logic [VW-1:0]     w_ax;
    logic [VW-1:0]     w_yf;
    logic [VW-1:0]     w_ay;
    logic              w_yneg;
    logic              w_fix;
    logic signed [AW-1:0] w_z0;

    logic              r_p_fix;
    logic              r_p_yneg;
    logic signed [AW-1:0] r_p_z;
    logic [MW-1:0]     r_p_ax;
    logic [MW-1:0]     r_p_ay;
    logic [MW-1:0]     r_p_m;

    always_comb begin
        w_xneg = i_x[VW-1];
        w_ax   = w_xneg ? (~i_x + 1'b1) : i_x;
        w_yf   = w_xneg ? (~i_y + 1'b1) : i_y;
        w_yneg = w_yf[VW-1];
        w_ay   = w_yneg ? (~w_yf + 1'b1) : w_yf;
        w_fix  = (i_x == '0);
        if (w_fix) begin
            if (i_y[VW-1])        w_z0 = -bla_pkg::DEG90;
            else if (i_y != '0)   w_z0 = bla_pkg::DEG90;
            else                  w_z0 = '0;
        end else if (w_xneg) begin
            w_z0 = i_y[VW-1] ? -bla_pkg::DEG180 : bla_pkg::DEG180;
        end else begin
            w_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_fix  <= w_fix;
            r_p_yneg <= w_yneg;
            r_p_z    <= w_z0;
            r_p_ax   <= MW'(w_ax);
            r_p_ay   <= MW'(w_ay);
            r_p_m    <= (w_ax > w_ay) ? MW'(w_ax) : MW'(w_ay);
        end
    end

    // normalize: shift by 32, 16, ... 1 until the larger magnitude has bit 56 set
    logic [MW-1:0]        r_n_ax   [NS];
    logic [MW-1:0]        r_n_ay   [NS];
    logic [MW-1:0]        r_n_m    [NS];
    logic                 r_n_fix  [NS];
    logic                 r_n_yneg [NS];
    logic signed [AW-1:0] r_n_z    [NS];
    logic [MW-1:0]        n_n_ax   [NS];
    logic [MW-1:0]        n_n_ay   [NS];
    logic [MW-1:0]        n_n_m    [NS];

    always_comb begin
        logic [MW-1:0] ax;
        logic [MW-1:0] ay;
        logic [MW-1:0] m;
        int            sh;
        for (int k = 0; k < NS; k++) begin
            ax = (k == 0) ? r_p_ax : r_n_ax[k-1];
            ay = (k == 0) ? r_p_ay : r_n_ay[k-1];
            m  = (k == 0) ? r_p_m  : r_n_m[k-1];
            sh = 1 << (NS - 1 - k);
            if ((m >> (MW - sh)) == '0) begin
                n_n_ax[k] = ax << sh;
                n_n_ay[k] = ay << sh;
                n_n_m[k]  = m << sh;
            end else begin
                n_n_ax[k] = ax;
                n_n_ay[k] = ay;
                n_n_m[k]  = m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_n_ax[k]   <= n_n_ax[k];
                r_n_ay[k]   <= n_n_ay[k];
                r_n_m[k]    <= n_n_m[k];
                r_n_fix[k]  <= (k == 0) ? r_p_fix  : r_n_fix[k-1];
                r_n_yneg[k] <= (k == 0) ? r_p_yneg : r_n_yneg[k-1];
                r_n_z[k]    <= (k == 0) ? r_p_z    : r_n_z[k-1];
            end
        end
    end

    // rotations; z starts at the quadrant base, held when x was zero
    logic signed [CW-1:0] r_x   [CS];
    logic signed [CW-1:0] r_y   [CS];
    logic signed [AW-1:0] r_z   [CS];
    logic                 r_fix [CS];
    logic signed [CW-1:0] n_x   [CS];
    logic signed [CW-1:0] n_y   [CS];
    logic signed [AW-1:0] n_z   [CS];

    always_comb begin
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 fx;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        for (int i = 0; i < CS; i++) begin
            if (i == 0) begin
                x  = $signed(CW'(r_n_ax[NS-1]));
                y  = r_n_yneg[NS-1] ? -$signed(CW'(r_n_ay[NS-1]))
                                    : $signed(CW'(r_n_ay[NS-1]));
                z  = r_n_z[NS-1];
                fx = r_n_fix[NS-1];
            end else begin
                x  = r_x[i-1];
                y  = r_y[i-1];
                z  = r_z[i-1];
                fx = r_fix[i-1];
            end
            xs = x >>> i;
            ys = y >>> i;
            if (fx) begin
                n_x[i] = x;
                n_y[i] = y;
                n_z[i] = z;
            end else if (!y[CW-1]) begin
                n_x[i] = x + ys;
                n_y[i] = y - xs;
                n_z[i] = z + bla_pkg::ATAN_TAB[i];
            end else begin
                n_x[i] = x - ys;
                n_y[i] = y + xs;
                n_z[i] = z - bla_pkg::ATAN_TAB[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CS; i++) begin
                r_x[i]   <= n_x[i];
                r_y[i]   <= n_y[i];
                r_z[i]   <= n_z[i];
                r_fix[i] <= (i == 0) ? r_n_fix[NS-1] : r_fix[i-1];
            end
        end
    end

    assign o_angle = r_z[CS-1];

endmodule

`default_nettype wire

### design/ballistic_low_arc_aim_core.sv
// ----------------------------------------------------------------------------
// ballistic_low_arc_aim_core
// Low-arc launch pitch and heading for a projectile at set speed and gravity.
// ----------------------------------------------------------------------------
// Takes one launch/target pair per cycle and returns one result per cycle, in
// order, while the output is not stalled, through 7 stages of products and the
// discriminant compare, a 42-stage bit-per-stage square root (one bit of the
// root per stage), one stage to form the CORDIC vectors, 27 CORDIC stages
// (fold, 6 normalizing-shift stages, 20 rotations) and the output register.
// The whole pipeline advances together; it halts only while the output
// register is full and stalled. Configuration writes are always ready and
// must be made while no item is in flight.
`default_nettype none
`include "ballistic_low_arc_aim_core_macros.svh"

module ballistic_low_arc_aim_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [23:0] i_start_x,
    input  wire logic signed [23:0] i_start_y,
    input  wire logic signed [23:0] i_start_z,
    input  wire logic signed [23:0] i_target_x,
    input  wire logic signed [23:0] i_target_y,
    input  wire logic signed [23:0] i_target_z,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_aim_status,
    output logic signed [15:0]      o_pitch_angle,
    output logic signed [16:0]      o_yaw_angle,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [16:0]        i_cfg_data
);

    localparam int SW = bla_pkg::SQ_IN_W;
    localparam int RW = bla_pkg::SQ_OUT_W;
    localparam int VW = bla_pkg::VEC_W;
    localparam int AW = bla_pkg::ANG_W;
    localparam int CL = bla_pkg::CORD_LAT;

    typedef struct packed {
        logic                 v;
        bla_pkg::t_aim_status st;
        logic                 dzpos;
        logic                 dzneg;
        logic                 g0;
        logic [31:0]          s2;
        logic [24:0]          dx;
        logic [24:0]          dy;
        logic [24:0]          dz;
    } t_side_sq;

    typedef struct packed {
        logic                 v;
        bla_pkg::t_aim_status st;
        logic                 dzpos;
        logic                 dzneg;
    } t_side_cd;

    // ---------------- configuration ----------------
    logic [15:0]        r_launch_speed;
    logic signed [16:0] r_gravity_accel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch_speed  <= '0;
            r_gravity_accel <= bla_pkg::GRAVITY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bla_pkg::t_cfg_index'(i_cfg_index))
                bla_pkg::CFG_LAUNCH_SPEED:  r_launch_speed  <= i_cfg_data[15:0];
                bla_pkg::CFG_GRAVITY_ACCEL: r_gravity_accel <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    logic r_out_valid;
    logic w_en;

    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    // ---------------- S1: differences and magnitudes ----------------
    logic [24:0] w_dx, w_dy, w_dz;
    logic [16:0] w_g;

    assign w_dx = {i_target_x[23], i_target_x} - {i_start_x[23], i_start_x};
    assign w_dy = {i_target_y[23], i_target_y} - {i_start_y[23], i_start_y};
    assign w_dz = {i_target_z[23], i_target_z} - {i_start_z[23], i_start_z};
    assign w_g  = r_gravity_accel[16] ? (~r_gravity_accel + 1'b1) : r_gravity_accel;

    logic        r1_v;
    logic [24:0] r1_dx, r1_dy, r1_dz;
    logic [24:0] r1_adx, r1_ady, r1_adz;
    logic [16:0] r1_g;
    logic [15:0] r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx  <= w_dx;
            r1_dy  <= w_dy;
            r1_dz  <= w_dz;
            r1_adx <= w_dx[24] ? (~w_dx + 1'b1) : w_dx;
            r1_ady <= w_dy[24] ? (~w_dy + 1'b1) : w_dy;
            r1_adz <= w_dz[24] ? (~w_dz + 1'b1) : w_dz;
            r1_g   <= w_g;
            r1_s   <= r_launch_speed;
        end
    end

    // ---------------- S2: first products ----------------
    logic        r2_v;
    logic [49:0] r2_xx, r2_yy;
    logic [31:0] r2_s2;
    logic [33:0] r2_gg;
    logic [41:0] r2_gz;
    logic [24:0] r2_dx, r2_dy, r2_dz;
    logic        r2_g0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_xx <= 50'(r1_adx) * 50'(r1_adx);
            r2_yy <= 50'(r1_ady) * 50'(r1_ady);
            r2_s2 <= 32'(r1_s) * 32'(r1_s);
            r2_gg <= 34'(r1_g) * 34'(r1_g);
            r2_gz <= 42'(r1_g) * 42'(r1_adz);
            r2_dx <= r1_dx;
            r2_dy <= r1_dy;
            r2_dz <= r1_dz;
            r2_g0 <= (r1_g == '0);
        end
    end

    // ---------------- S3: D2, s^4, g*|dz|*s^2 halves ----------------
    logic        r3_v;
    logic [49:0] r3_d2;
    logic [63:0] r3_s4;
    logic [57:0] r3_tzlo, r3_tzhi;
    logic [33:0] r3_gg;
    logic [31:0] r3_s2;
    logic [24:0] r3_dx, r3_dy, r3_dz;
    logic        r3_g0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_d2   <= r2_xx + r2_yy;
            r3_s4   <= 64'(r2_s2) * 64'(r2_s2);
            r3_tzlo <= 58'(r2_gz) * 58'(r2_s2[15:0]);
            r3_tzhi <= 58'(r2_gz) * 58'(r2_s2[31:16]);
            r3_gg   <= r2_gg;
            r3_s2   <= r2_s2;
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_dz   <= r2_dz;
            r3_g0   <= r2_g0;
        end
    end

    // ---------------- S4: g^2*D2 halves, 2*g*|dz|*s^2 ----------------
    logic          r4_v;
    logic [58:0]   r4_gdlo, r4_gdhi;
    logic [SW-1:0] r4_tz;
    logic [63:0]   r4_s4;
    logic [49:0]   r4_d2;
    logic [31:0]   r4_s2;
    logic [24:0]   r4_dx, r4_dy, r4_dz;
    logic          r4_g0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_gdlo <= 59'(r3_gg) * 59'(r3_d2[24:0]);
            r4_gdhi <= 59'(r3_gg) * 59'(r3_d2[49:25]);
            r4_tz   <= (SW'(r3_tzlo) + (SW'(r3_tzhi) << 16)) << 1;
            r4_s4   <= r3_s4;
            r4_d2   <= r3_d2;
            r4_s2   <= r3_s2;
            r4_dx   <= r3_dx;
            r4_dy   <= r3_dy;
            r4_dz   <= r3_dz;
            r4_g0   <= r3_g0;
        end
    end

    // ---------------- S5: g^2*D2 and the positive side ----------------
    logic          r5_v;
    logic [SW-1:0] r5_gd, r5_pos, r5_tz;
    logic [49:0]   r5_d2;
    logic [31:0]   r5_s2;
    logic [24:0]   r5_dx, r5_dy, r5_dz;
    logic          r5_g0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_gd  <= SW'(r4_gdlo) + (SW'(r4_gdhi) << 25);
            r5_pos <= SW'(r4_s4) + (r4_dz[24] ? r4_tz : '0);
            r5_tz  <= r4_tz;
            r5_d2  <= r4_d2;
            r5_s2  <= r4_s2;
            r5_dx  <= r4_dx;
            r5_dy  <= r4_dy;
            r5_dz  <= r4_dz;
            r5_g0  <= r4_g0;
        end
    end

    // ---------------- S6: negative side ----------------
    logic          r6_v;
    logic [SW-1:0] r6_gd, r6_pos, r6_neg;
    logic [49:0]   r6_d2;
    logic [31:0]   r6_s2;
    logic [24:0]   r6_dx, r6_dy, r6_dz;
    logic          r6_g0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_neg <= r5_gd + (r5_dz[24] ? '0 : r5_tz);
            r6_gd  <= r5_gd;
            r6_pos <= r5_pos;
            r6_d2  <= r5_d2;
            r6_s2  <= r5_s2;
            r6_dx  <= r5_dx;
            r6_dy  <= r5_dy;
            r6_dz  <= r5_dz;
            r6_g0  <= r5_g0;
        end
    end

    // ---------------- S7: reach test and radicands ----------------
    bla_pkg::t_aim_status w_st6;
    t_side_sq             r7_side;
    logic [SW-1:0]        r7_root_sq, r7_h_sq;

    always_comb begin
        if (r6_neg > r6_pos)     w_st6 = bla_pkg::ST_UNREACH;
        else if (r6_d2 == '0)    w_st6 = bla_pkg::ST_VERTICAL;
        else                     w_st6 = bla_pkg::ST_SOLVED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_side.v <= 1'b0;
        end else if (w_en) begin
            r7_side.v <= r6_v;
        end
        if (w_en) begin
            r7_side.st    <= w_st6;
            r7_side.dzpos <= !r6_dz[24] && (r6_dz != '0);
            r7_side.dzneg <= r6_dz[24];
            r7_side.g0    <= r6_g0;
            r7_side.s2    <= r6_s2;
            r7_side.dx    <= r6_dx;
            r7_side.dy    <= r6_dy;
            r7_side.dz    <= r6_dz;
            r7_root_sq    <= r6_pos - r6_neg;
            // zero gravity: line of sight, horizontal leg scaled by 256
            r7_h_sq       <= r6_g0 ? (SW'(r6_d2) << 16) : r6_gd;
        end
    end

    // ---------------- square roots ----------------
    logic [RW-1:0] w_root_rt, w_h_rt;

    bla_isqrt u_sqrt_root (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r7_root_sq),
        .o_root (w_root_rt)
    );

    bla_isqrt u_sqrt_h (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r7_h_sq),
        .o_root (w_h_rt)
    );

    t_side_sq r_sq_line [RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) r_sq_line[k].v <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k < RW; k++) begin
                r_sq_line[k] <= (k == 0) ? r7_side : r_sq_line[k-1];
            end
        end
    end

    // ---------------- S8: CORDIC vectors ----------------
    t_side_cd             r8_side;
    logic signed [VW-1:0] r8_py, r8_px, r8_yy, r8_yx;
    t_side_sq             w_sq_end;

    assign w_sq_end = r_sq_line[RW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_side.v <= 1'b0;
        end else if (w_en) begin
            r8_side.v <= w_sq_end.v;
        end
        if (w_en) begin
            r8_side.st    <= w_sq_end.st;
            r8_side.dzpos <= w_sq_end.dzpos;
            r8_side.dzneg <= w_sq_end.dzneg;
            r8_py <= w_sq_end.g0
                   ? $signed({{(VW-33){w_sq_end.dz[24]}}, w_sq_end.dz, 8'b0})
                   : $signed(VW'(w_sq_end.s2) - VW'(w_root_rt));
            r8_px <= $signed(VW'(w_h_rt));
            r8_yy <= $signed({{(VW-25){w_sq_end.dy[24]}}, w_sq_end.dy});
            r8_yx <= $signed({{(VW-25){w_sq_end.dx[24]}}, w_sq_end.dx});
        end
    end

    // ---------------- arctangents ----------------
    logic signed [AW-1:0] w_pitch_ang, w_yaw_ang;

    bla_cordic u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r8_py),
        .i_x     (r8_px),
        .o_angle (w_pitch_ang)
    );

    bla_cordic u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r8_yy),
        .i_x     (r8_yx),
        .o_angle (w_yaw_ang)
    );

    t_side_cd r_cd_line [CL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CL; k++) r_cd_line[k].v <= 1'b0;
        end else if (w_en) begin
            for (int k = 0; k < CL; k++) begin
                r_cd_line[k] <= (k == 0) ? r8_side : r_cd_line[k-1];
            end
        end
    end

    // ---------------- output: round to 1/256 degree, clamp, select ----------------
    t_side_cd             w_cd_end;
    logic signed [AW:0]   w_p_sum, w_y_sum;
    logic signed [AW-8:0] w_p_q, w_y_q;
    logic signed [15:0]   w_pitch_sol;
    logic signed [16:0]   w_yaw_sol;
    logic signed [15:0]   n_pitch;
    logic signed [16:0]   n_yaw;

    assign w_cd_end = r_cd_line[CL-1];

    always_comb begin
        w_p_sum = $signed({w_pitch_ang[AW-1], w_pitch_ang}) + (AW+1)'(128);
        w_y_sum = $signed({w_yaw_ang[AW-1], w_yaw_ang}) + (AW+1)'(128);
        w_p_q   = (AW-7)'(w_p_sum >>> 8);
        w_y_q   = (AW-7)'(w_y_sum >>> 8);

        if (w_p_q > (AW-7)'(bla_pkg::PITCH_MAX))        w_pitch_sol = bla_pkg::PITCH_MAX;
        else if (w_p_q < -(AW-7)'(bla_pkg::PITCH_MAX))  w_pitch_sol = -bla_pkg::PITCH_MAX;
        else                                            w_pitch_sol = w_p_q[15:0];

        if (w_y_q > (AW-7)'(bla_pkg::YAW_MAX))          w_yaw_sol = bla_pkg::YAW_MAX;
        else if (w_y_q < -(AW-7)'(bla_pkg::YAW_MAX))    w_yaw_sol = -bla_pkg::YAW_MAX;
        else                                            w_yaw_sol = w_y_q[16:0];

        case (w_cd_end.st)
            bla_pkg::ST_SOLVED: begin
                n_pitch = w_pitch_sol;
                n_yaw   = w_yaw_sol;
            end
            bla_pkg::ST_VERTICAL: begin
                if (w_cd_end.dzpos)      n_pitch = bla_pkg::PITCH_MAX;
                else if (w_cd_end.dzneg) n_pitch = -bla_pkg::PITCH_MAX;
                else                     n_pitch = '0;
                n_yaw = '0;
            end
            default: begin
                n_pitch = '0;
                n_yaw   = '0;
            end
        endcase
    end

    logic [1:0]         r_out_status;
    logic signed [15:0] r_out_pitch;
    logic signed [16:0] r_out_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cd_end.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_status <= w_cd_end.st;
            r_out_pitch  <= n_pitch;
            r_out_yaw    <= n_yaw;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_aim_status  = r_out_status;
    assign o_pitch_angle = r_out_pitch;
    assign o_yaw_angle   = r_out_yaw;

    // ---------------- assertions ----------------
    `BLA_ASSERT(a_unreach_zero, (o_out_valid && o_aim_status == bla_pkg::ST_UNREACH) |-> (o_pitch_angle == '0 && o_yaw_angle == '0), "out of reach result carries nonzero angles")
    `BLA_ASSERT(a_vertical_form, (o_out_valid && o_aim_status == bla_pkg::ST_VERTICAL) |-> (o_yaw_angle == '0 && (o_pitch_angle == bla_pkg::PITCH_MAX || o_pitch_angle == -bla_pkg::PITCH_MAX || o_pitch_angle == '0)), "vertical result malformed")
    `BLA_ASSERT(a_pitch_range, o_out_valid |-> (o_pitch_angle <= bla_pkg::PITCH_MAX && o_pitch_angle >= -bla_pkg::PITCH_MAX && o_yaw_angle <= bla_pkg::YAW_MAX && o_yaw_angle >= -bla_pkg::YAW_MAX), "angle outside clamp range")
    `BLA_ASSERT_NEXT(a_hold_s8, (!w_en && r8_side.v), r8_side.v, "pipeline lost an item during stall")

endmodule

`default_nettype wire

### tb/ballistic_low_arc_aim_core_tb.sv
// ----------------------------------------------------------------------------
// ballistic_low_arc_aim_core_tb
// Self-checking bench for the low-arc aim core. Directed rows and random
// launch/target pairs run under several speed and gravity settings; every
// transfer out is compared against a listed or locally solved result, with
// random idling and stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ballistic_low_arc_aim_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 100;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [23:0]   sx, sy, sz, tx, ty, tz;
        bit                   typed;
        bla_pkg::t_aim_status st;
        logic signed [15:0]   pitch;
        logic signed [16:0]   yaw;
    } t_aim_row;

    typedef struct {
        bla_pkg::t_aim_status st;
        logic signed [15:0]   pitch;
        logic signed [16:0]   yaw;
    } t_aim_sol;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [23:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [23:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_aim_status;
    logic signed [15:0] o_pitch_angle;
    logic signed [16:0] o_yaw_angle;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [16:0]        i_cfg_data = '0;

    ballistic_low_arc_aim_core dut (.*);

    logic [15:0]        speed_reg;
    logic signed [16:0] grav_reg;
    t_aim_sol           pending_q[$];
    t_aim_row           rows[$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 quiet = 0;
    bit                 hold_req = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- solver ----------------
    function automatic logic [63:0] isqrt(logic [127:0] v);
        logic [63:0]  res;
        logic [63:0]  cand;
        logic [127:0] sq;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            sq = 128'(cand);
            sq = sq * sq;
            if (sq <= v) res = cand;
        end
        return res;
    endfunction

    // atan2 in 1/65536 degree
    function automatic longint vec_angle(longint y, longint x);
        longint      base, z, xs, ys;
        logic [63:0] ax, ay, m;
        bit          yneg;
        base = 0;
        z = 0;
        if (x == 0) return y > 0 ? 64'sd5898240 : (y < 0 ? -64'sd5898240 : 64'sd0);
        if (x < 0) begin
            base = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
            x = -x;
            y = -y;
        end
        yneg = y < 0;
        ax = x;
        ay = yneg ? -y : y;
        m = ax > ay ? ax : ay;
        while (m < (64'd1 << 56)) begin
            m = m << 1;
            ax = ax << 1;
            ay = ay << 1;
        end
        x = ax;
        y = yneg ? -longint'(ay) : longint'(ay);
        for (int i = 0; i < bla_pkg::CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += 64'(bla_pkg::ATAN_TAB[i]);
            end else begin
                x -= ys; y += xs; z -= 64'(bla_pkg::ATAN_TAB[i]);
            end
        end
        return base + z;
    endfunction

    function automatic longint fine_to_out(longint a, longint lim);
        longint r;
        r = (a + 128) >>> 8;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_aim_sol solve_aim(t_aim_row r);
        t_aim_sol     o;
        longint       dx, dy, dz, ny, hx;
        logic [63:0]  adx, ady, adz, s, g, s2, d2;
        logic [127:0] gd, tzp, pos, neg;
        dx = longint'(r.tx) - longint'(r.sx);
        dy = longint'(r.ty) - longint'(r.sy);
        dz = longint'(r.tz) - longint'(r.sz);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        adz = dz < 0 ? -dz : dz;
        s = 64'(speed_reg);
        g = grav_reg < 0 ? -longint'(grav_reg) : longint'(grav_reg);
        s2 = s * s;
        d2 = adx * adx + ady * ady;
        gd = 128'(g * g) * 128'(d2);
        tzp = 128'(2 * g * adz) * 128'(s2);
        pos = 128'(s2) * 128'(s2);
        neg = gd;
        if (dz < 0) pos = pos + tzp;
        else neg = neg + tzp;
        o.st = bla_pkg::ST_SOLVED;
        o.pitch = '0;
        o.yaw = '0;
        if (neg > pos) begin
            o.st = bla_pkg::ST_UNREACH;
        end else if (d2 == 0) begin
            o.st = bla_pkg::ST_VERTICAL;
            o.pitch = dz > 0 ? bla_pkg::PITCH_MAX
                             : (dz < 0 ? -bla_pkg::PITCH_MAX : 16'sd0);
        end else begin
            o.yaw = 17'(fine_to_out(vec_angle(dy, dx), 64'(bla_pkg::YAW_MAX)));
            if (g == 0) begin
                hx = isqrt(128'(d2) * 128'd65536);
                o.pitch = 16'(fine_to_out(vec_angle(dz * 256, hx),
                                          64'(bla_pkg::PITCH_MAX)));
            end else begin
                ny = longint'(s2) - longint'(isqrt(pos - neg));
                hx = isqrt(gd);
                o.pitch = 16'(fine_to_out(vec_angle(ny, hx), 64'(bla_pkg::PITCH_MAX)));
            end
        end
        return o;
    endfunction

    // ---------------- driving ----------------
    function automatic int pick_gap();
        if (quiet) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
        return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2);
    endfunction

    // called right after a rising edge
    task automatic send_aim(t_aim_row r);
        t_aim_sol e;
        int       n;
        i_in_valid <= 1'b1;
        i_start_x <= r.sx; i_start_y <= r.sy; i_start_z <= r.sz;
        i_target_x <= r.tx; i_target_y <= r.ty; i_target_z <= r.tz;
        do @(posedge i_clk); while (o_in_stall);
        if (r.typed) begin
            e.st = r.st; e.pitch = r.pitch; e.yaw = r.yaw;
        end else begin
            e = solve_aim(r);
        end
        pending_q.push_back(e);
        n = pick_gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic idle_until_drained();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic write_reg(bla_pkg::t_cfg_index idx, logic [16:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == bla_pkg::CFG_LAUNCH_SPEED) speed_reg = val[15:0];
        else grav_reg = val;
        @(posedge i_clk);
    endtask

    function automatic t_aim_row mk_row(int sx, int sy, int sz, int tx, int ty, int tz,
                                        bit typed = 0,
                                        bla_pkg::t_aim_status st = bla_pkg::ST_SOLVED,
                                        int pitch = 0, int yaw = 0);
        t_aim_row r;
        r.sx = 24'(sx); r.sy = 24'(sy); r.sz = 24'(sz);
        r.tx = 24'(tx); r.ty = 24'(ty); r.tz = 24'(tz);
        r.typed = typed; r.st = st; r.pitch = 16'(pitch); r.yaw = 17'(yaw);
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(longint v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return 24'(v);
    endfunction

    function automatic t_aim_row rand_row();
        t_aim_row r;
        int       k;
        r.typed = 0;
        r.st = bla_pkg::ST_SOLVED;
        r.pitch = '0;
        r.yaw = '0;
        r.sx = 24'($urandom); r.sy = 24'($urandom); r.sz = 24'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            r.tx = 24'($urandom); r.ty = 24'($urandom); r.tz = 24'($urandom);
        end else begin
            // nearby target at a random scale, mostly reachable distances
            k = $urandom_range(0, 20);
            r.tx = sat24(longint'(r.sx) + $signed($urandom_range(0, 2 << k)) - (1 << k));
            k = $urandom_range(0, 20);
            r.ty = sat24(longint'(r.sy) + $signed($urandom_range(0, 2 << k)) - (1 << k));
            k = $urandom_range(0, 18);
            r.tz = sat24(longint'(r.sz) + $signed($urandom_range(0, 2 << k)) - (1 << k));
            case ($urandom_range(0, 9))
                0: begin r.tx = r.sx; r.ty = r.sy; end
                1: r.tx = r.sx;
                2: r.ty = r.sy;
                default: ;
            endcase
        end
        return r;
    endfunction

    // ---------------- output side ----------------
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_aim_sol e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_aim_status !== e.st) begin
                    $error("aim_status exp %0d got %0d", e.st, o_aim_status);
                    errors++;
                end
                if (o_pitch_angle !== e.pitch) begin
                    $error("pitch_angle exp %0d got %0d", e.pitch, o_pitch_angle);
                    errors++;
                end
                if (o_yaw_angle !== e.yaw) begin
                    $error("yaw_angle exp %0d got %0d", e.yaw, o_yaw_angle);
                    errors++;
                end
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        logic [15:0]        spd[6];
        logic signed [16:0] grv[6];
        speed_reg = 16'd0;
        grav_reg = bla_pkg::GRAVITY_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero speed, everything off-axis is out of reach
        rows.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, bla_pkg::ST_VERTICAL, 0, 0));
        rows.push_back(mk_row(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                              1, bla_pkg::ST_VERTICAL, 0, 0));
        rows.push_back(mk_row(0, 0, 0, 0, 0, 8388607, 1, bla_pkg::ST_VERTICAL, 23040, 0));
        rows.push_back(mk_row(0, 0, 8388607, 0, 0, -8388608,
                              1, bla_pkg::ST_VERTICAL, -23040, 0));
        rows.push_back(mk_row(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                              1, bla_pkg::ST_UNREACH, 0, 0));
        rows.push_back(mk_row(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                              1, bla_pkg::ST_UNREACH, 0, 0));
        rows.push_back(mk_row(0, 0, 0, 1, 0, 0, 1, bla_pkg::ST_UNREACH, 0, 0));
        rows.push_back(mk_row(0, 0, 0, 0, -1, 0, 1, bla_pkg::ST_UNREACH, 0, 0));
        foreach (rows[i]) send_aim(rows[i]);
        idle_until_drained();
        rows.delete();

        // zero gravity: line of sight, each axis heading incl. the +/-180 split
        write_reg(bla_pkg::CFG_LAUNCH_SPEED, 17'd65535);
        write_reg(bla_pkg::CFG_GRAVITY_ACCEL, 17'd0);
        rows.push_back(mk_row(0, 0, 0, 100, 0, 0));
        rows.push_back(mk_row(0, 0, 0, 0, 100, 100));
        rows.push_back(mk_row(0, 0, 0, -100, 0, -100));
        rows.push_back(mk_row(0, 0, 0, -100, -1, 0));
        rows.push_back(mk_row(0, 0, 0, 0, -100, 0));
        rows.push_back(mk_row(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
        rows.push_back(mk_row(8388607, 0, 8388607, -8388608, 0, -8388608));
        rows.push_back(mk_row(0, 0, 0, 1, 1, 8388607));
        foreach (rows[i]) send_aim(rows[i]);
        idle_until_drained();
        rows.delete();

        spd = '{16'd65535, 16'd0, 16'd20000, 16'd65535, 16'd9000, 16'd3000};
        grv = '{17'h10000, 17'sd980, 17'sd980, 17'sd1, 17'sd65535, 17'sd0};
        for (int ph = 0; ph < 7; ph++) begin
            if (ph < 6) begin
                write_reg(bla_pkg::CFG_LAUNCH_SPEED, {1'($urandom), spd[ph]});
                write_reg(bla_pkg::CFG_GRAVITY_ACCEL, grv[ph]);
            end else begin
                write_reg(bla_pkg::CFG_LAUNCH_SPEED, 17'($urandom));
                write_reg(bla_pkg::CFG_GRAVITY_ACCEL, 17'($urandom));
            end
            quiet = (ph == 4);
            if (ph == 2) hold_req = 1;
            repeat (105) send_aim(rand_row());
            quiet = 0;
            idle_until_drained();
        end

        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/bla_pkg.sv
design/bla_isqrt.sv
design/bla_cordic.sv
design/ballistic_low_arc_aim_core.sv
tb/ballistic_low_arc_aim_core_tb.sv
